@@ rtl/agc_pkg.sv @@
`default_nettype none

package agc_pkg;

  // Field widths
  localparam int unsigned BTN_W    = 5;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned LEVEL_W  = 15;
  localparam int unsigned STEP_W   = 4;

  // Button bit positions (active low pins)
  localparam int unsigned BIT_DOWN = 1;
  localparam int unsigned BIT_UP   = 3;
  localparam int unsigned BIT_MODE = 4;

  // Gain step table size and limits
  localparam int unsigned NUM_STEPS = 16;
  localparam logic [STEP_W-1:0] STEP_MAX   = STEP_W'(NUM_STEPS - 1);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(8);

  // Level limits and reset values
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX    = LEVEL_W'(16384);
  localparam logic [LEVEL_W-1:0]  LEVEL_RESET  = LEVEL_W'(3000);
  localparam logic [SAMPLE_W-1:0] TARGET_RESET = SAMPLE_W'(2048);
  localparam logic [BTN_W-1:0]    BTN_RELEASED = '1;

  // One control period as held in the input register
  typedef struct packed {
    logic [BTN_W-1:0]    buttons;
    logic [SAMPLE_W-1:0] sample;
  } agc_item_t;

endpackage

`default_nettype wire

@@ rtl/agc_manual_gain_controller.sv @@
`default_nettype none

// Gain controller, one control period per transaction. Accepts one item every
// clock cycle while results are taken; each item passes the input register,
// then the result register, and the loop state moves at the same edge that
// loads the result register. A stalled result holds both
// stages. Falling edges on the down/up buttons step a
// gain index (0..15, saturating); a falling edge on the mode button toggles
// manual mode. In manual mode gain_code is 1024*(index+1), otherwise the
// automatic loop level, taken before this period's sample moves the level by
// target_level minus the sample (saturating at 0 and 16384). target_level is
// written through the cfg channel, which is always ready; write it only when
// no transaction is in flight.
module agc_manual_gain_controller
  import agc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [SAMPLE_W-1:0] cfg_target_level_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [BTN_W-1:0]    button_levels_i,
  input  wire logic [SAMPLE_W-1:0] level_sample_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [LEVEL_W-1:0]       gain_code_o,
  output logic                     manual_mode_o,
  output logic [STEP_W-1:0]        step_index_o
);

  agc_item_t in_item, reg_item;
  logic      reg_valid, core_ready;

  assign cfg_ready_o     = 1'b1;
  assign in_item.buttons = button_levels_i;
  assign in_item.sample  = level_sample_i;

  // Input register
  agc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .valid_o (reg_valid),
    .ready_i (core_ready),
    .item_o  (reg_item)
  );

  // Button edges, loop state and result register
  agc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_target_i  (cfg_target_level_i),
    .valid_i       (reg_valid),
    .ready_o       (core_ready),
    .item_i        (reg_item),
    .valid_o       (out_valid_o),
    .ready_i       (out_ready_i),
    .gain_code_o   (gain_code_o),
    .manual_mode_o (manual_mode_o),
    .step_index_o  (step_index_o)
  );

endmodule

`default_nettype wire

@@ rtl/agc_in_reg.sv @@
`default_nettype none

module agc_in_reg
  import agc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  output logic           ready_o,
  input  wire agc_item_t item_i,
  output logic           valid_o,
  input  wire logic      ready_i,
  output agc_item_t      item_o
);

  logic      valid_q;
  agc_item_t item_q;

  // Slot frees when empty or when the core takes it this cycle
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/agc_core.sv @@
`default_nettype none

module agc_core
  import agc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [SAMPLE_W-1:0] cfg_target_i,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire agc_item_t           item_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output logic [LEVEL_W-1:0]       gain_code_o,
  output logic                     manual_mode_o,
  output logic [STEP_W-1:0]        step_index_o
);

  logic [SAMPLE_W-1:0] target_q;
  logic [BTN_W-1:0]    prev_q, falls;
  logic                mode_q, mode_d;
  logic [STEP_W-1:0]   step_q, step_dn, step_d;
  logic [LEVEL_W-1:0]  level_q, level_d;
  logic [LEVEL_W-1:0]  code_d;
  logic [SAMPLE_W-1:0] diff;
  logic [LEVEL_W-1:0]  diff_w, headroom;
  logic [STEP_W:0]     step_p1;
  logic                fire;

  logic                out_valid_q;
  logic [LEVEL_W-1:0]  code_q;
  logic                mode_out_q;
  logic [STEP_W-1:0]   step_out_q;

  assign ready_o = !out_valid_q || ready_i;
  assign fire    = valid_i && ready_o;

  // Falling edges on the button pins
  assign falls = ~item_i.buttons & prev_q;

  // Step index: down first, then up, both saturating
  always_comb begin
    step_dn = step_q;
    if (falls[BIT_DOWN] && (step_q != '0)) begin
      step_dn = step_q - STEP_W'(1);
    end
    step_d = step_dn;
    if (falls[BIT_UP] && (step_dn != STEP_MAX)) begin
      step_d = step_dn + STEP_W'(1);
    end
  end

  assign mode_d  = mode_q ^ falls[BIT_MODE];
  assign step_p1 = {1'b0, step_d} + (STEP_W+1)'(1);

  // Output code: 1024 per step in manual mode, the loop level otherwise
  assign code_d = mode_d ? {step_p1, 10'b0} : level_q;

  // Loop level update from target minus sample, saturating both ways
  always_comb begin
    headroom = LEVEL_MAX - level_q;
    if (item_i.sample > target_q) begin
      diff    = item_i.sample - target_q;
      diff_w  = LEVEL_W'(diff);
      level_d = (level_q <= diff_w) ? '0 : level_q - diff_w;
    end else begin
      diff    = target_q - item_i.sample;
      diff_w  = LEVEL_W'(diff);
      level_d = (headroom <= diff_w) ? LEVEL_MAX : level_q + diff_w;
    end
  end

  // Control state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= TARGET_RESET;
      prev_q      <= BTN_RELEASED;
      mode_q      <= 1'b0;
      step_q      <= STEP_RESET;
      level_q     <= LEVEL_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        target_q <= cfg_target_i;
      end
      if (fire) begin
        prev_q  <= item_i.buttons;
        mode_q  <= mode_d;
        step_q  <= step_d;
        level_q <= level_d;
      end
      if (ready_o) begin
        out_valid_q <= valid_i;
      end
    end
  end

  // Result register, no reset
  always_ff @(posedge clk_i) begin
    if (fire) begin
      code_q     <= code_d;
      mode_out_q <= mode_d;
      step_out_q <= step_d;
    end
  end

  assign valid_o       = out_valid_q;
  assign gain_code_o   = code_q;
  assign manual_mode_o = mode_out_q;
  assign step_index_o  = step_out_q;

`ifndef ASSERT_OFF
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LEVEL_MAX)
    else $error("loop level above its ceiling");

  a_manual_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && mode_out_q) |->
      (code_q[9:0] == 10'b0) &&
      (code_q[LEVEL_W-1:10] == ({1'b0, step_out_q} + (STEP_W+1)'(1))))
    else $error("manual gain code does not match step index");

  a_step_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !falls[BIT_DOWN] && !falls[BIT_UP]) |=> $stable(step_q))
    else $error("step index moved without a button edge");

  a_mode_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !falls[BIT_MODE]) |=> $stable(mode_q))
    else $error("mode changed without a mode button edge");
`endif

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none

module testbench;
  import agc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One result as the block presents it
  typedef struct packed {
    logic [LEVEL_W-1:0] code;
    logic               manual;
    logic [STEP_W-1:0]  step;
  } gain_result_t;

  // Tracks the controller state and holds the gains still owed by the block
  class gain_checker;
    logic [BTN_W-1:0]    last_buttons;
    logic                manual;
    logic [STEP_W-1:0]   step;
    logic [LEVEL_W-1:0]  level;
    logic [SAMPLE_W-1:0] target;
    gain_result_t        expected_gains[$];
    int                  errors;
    int                  periods;
    int                  checked;

    function new();
      last_buttons = BTN_RELEASED;
      manual       = 1'b0;
      step         = STEP_RESET;
      level        = LEVEL_RESET;
      target       = TARGET_RESET;
      errors       = 0;
      periods      = 0;
      checked      = 0;
    endfunction

    function void set_target(logic [SAMPLE_W-1:0] value);
      target = value;
    endfunction

    function int pending();
      return expected_gains.size();
    endfunction

    // One accepted control period: edges, steps, mode, then the level moves
    function void note_period(logic [BTN_W-1:0] buttons, logic [SAMPLE_W-1:0] sample);
      logic [BTN_W-1:0] falls;
      gain_result_t     res;
      int               diff;
      falls = ~buttons & last_buttons;
      last_buttons = buttons;
      if (falls[BIT_DOWN] && step != '0) step = step - 1'b1;
      if (falls[BIT_UP] && step != STEP_MAX) step = step + 1'b1;
      if (falls[BIT_MODE]) manual = ~manual;
      res.code   = manual ? LEVEL_W'(1024 * (int'(step) + 1)) : level;
      res.manual = manual;
      res.step   = step;
      expected_gains.push_back(res);
      periods++;
      if (sample > target) begin
        diff  = int'(sample) - int'(target);
        level = (int'(level) <= diff) ? '0 : LEVEL_W'(int'(level) - diff);
      end else begin
        diff  = int'(target) - int'(sample);
        level = (int'(LEVEL_MAX) - int'(level) <= diff) ? LEVEL_MAX :
                LEVEL_W'(int'(level) + diff);
      end
    endfunction

    function void check_result(gain_result_t got);
      gain_result_t exp_res;
      if (expected_gains.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: code=%0d manual=%0d step=%0d",
                   got.code, got.manual, got.step);
        return;
      end
      exp_res = expected_gains.pop_front();
      if (got !== exp_res) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: expected code=%0d manual=%0d step=%0d, got code=%0d manual=%0d step=%0d",
                   checked, exp_res.code, exp_res.manual, exp_res.step,
                   got.code, got.manual, got.step);
      end
      checked++;
    endfunction

    // Anything still owed at the end is a failure
    function void close_out();
      if (expected_gains.size() != 0) begin
        $display("%0d results never arrived", expected_gains.size());
        errors += expected_gains.size();
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [SAMPLE_W-1:0] cfg_target_level_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [BTN_W-1:0]    button_levels_i = BTN_RELEASED;
  logic [SAMPLE_W-1:0] level_sample_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [LEVEL_W-1:0]  gain_code_o;
  logic                manual_mode_o;
  logic [STEP_W-1:0]   step_index_o;

  gain_checker gains = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int target_writes = 0;

  agc_manual_gain_controller u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_target_level_i (cfg_target_level_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .button_levels_i    (button_levels_i),
    .level_sample_i     (level_sample_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .gain_code_o        (gain_code_o),
    .manual_mode_o      (manual_mode_o),
    .step_index_o       (step_index_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("agc_manual_gain_controller verification failed");
    $finish;
  end

  // Result side: check each accepted transaction, then pick next ready
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        gains.check_result('{gain_code_o, manual_mode_o, step_index_o});
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one control period and wait for its transaction
  task automatic send_period(input logic [BTN_W-1:0] buttons, input logic [SAMPLE_W-1:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    button_levels_i <= buttons;
    level_sample_i  <= sample;
    do @(posedge clk_i); while (!in_ready_o);
    gains.note_period(buttons, sample);
  endtask

  // Drain everything in flight
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (gains.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Target write, only ever issued with the block drained
  task automatic write_target(input logic [SAMPLE_W-1:0] value);
    wait_drained();
    cfg_valid_i        <= 1'b1;
    cfg_target_level_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    gains.set_target(value);
    target_writes++;
  endtask

  // Extremes, values near the target, or anything
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(9))
      0: v = 0;
      1: v = 4095;
      2, 3, 4: begin
        v = int'(gains.target) + int'($urandom_range(64)) - 32;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
      default: v = $urandom_range(4095);
    endcase
    return SAMPLE_W'(v);
  endfunction

  // Mostly press/release runs on one button, some raw noise on the pins
  task automatic run_random(input int n);
    int               sent;
    int               reps;
    int               which;
    logic [BTN_W-1:0] rest;
    logic [BTN_W-1:0] press;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 70) begin
        rest = BTN_RELEASED;
        // pins without function may be held low meanwhile
        if ($urandom_range(3) == 0) rest[0] = 1'b0;
        if ($urandom_range(3) == 0) rest[2] = 1'b0;
        which = $urandom_range(9);
        press = rest;
        case (which)
          0, 1, 2: press[BIT_DOWN] = 1'b0;
          3, 4, 5: press[BIT_UP] = 1'b0;
          6:       press[BIT_MODE] = 1'b0;
          7: begin
            press[BIT_DOWN] = 1'b0;
            press[BIT_UP]   = 1'b0;
          end
          8:       press[0] = 1'b0;
          default: press[2] = 1'b0;
        endcase
        reps = $urandom_range(20, 1);
        for (int k = 0; k < reps && sent < n; k++) begin
          send_period(press, pick_sample());
          send_period(rest, pick_sample());
          sent += 2;
        end
      end else begin
        reps = $urandom_range(8, 1);
        for (int k = 0; k < reps && sent < n; k++) begin
          send_period(BTN_W'($urandom_range(31)), SAMPLE_W'($urandom_range(4095)));
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: level climbs to its ceiling, all edges at once, mode alone,
    // down presses past zero, then down and up together at zero
    send_idle_pct = 20;
    recv_idle_pct = 20;
    write_target(12'd4095);
    send_period(5'h1F, 12'd0);
    send_period(5'h00, 12'd0);
    send_period(5'h1F, 12'd4095);
    send_period(5'h0F, 12'd0);
    for (int k = 0; k < 9; k++) begin
      send_period(5'h1D, (k % 2) ? 12'd4095 : 12'd0);
      send_period(5'h1F, 12'd0);
    end
    send_period(5'h15, 12'd0);

    // Directed: level falls to its floor, then sample equal to a zero target
    write_target(12'd0);
    for (int k = 0; k < 5; k++) send_period(5'h1F, 12'd4095);
    send_period(5'h1F, 12'd0);

    // Sender idles more rarely than the receiver
    send_idle_pct = 30;
    recv_idle_pct = 52;
    write_target(SAMPLE_W'($urandom_range(4095)));
    run_random(250);
    write_target(12'd0);
    run_random(250);

    // Then the other way round
    send_idle_pct = 52;
    recv_idle_pct = 30;
    write_target(12'd4095);
    run_random(250);
    write_target(SAMPLE_W'($urandom_range(4095)));
    run_random(250);

    // Full rate, with one long receiver hold-off to back the block up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_target(SAMPLE_W'($urandom_range(4095)));
    hold_request = 300;
    run_random(250);
    write_target(TARGET_RESET);
    run_random(250);

    wait_drained();
    repeat (10) @(posedge clk_i);
    gains.close_out();
    $display("%0d control periods sent, %0d results checked, %0d target settings",
             gains.periods, gains.checked, target_writes);
    if (gains.errors == 0) begin
      $display("agc_manual_gain_controller verification clean");
    end else begin
      $display("%0d mismatches in total", gains.errors);
      $display("agc_manual_gain_controller verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ agc_manual_gain_controller.f @@
rtl/agc_pkg.sv
rtl/agc_in_reg.sv
rtl/agc_core.sv
rtl/agc_manual_gain_controller.sv
dv/testbench.sv
